>>> rtl/core/ssbr_pkg.sv
// shared types and constants of the supersample box resolve
`timescale 1ns / 1ps

package ssbr_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_SAMPLE_RATE   = 2'd0;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd1;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd2;

    localparam int RATE_W  = 3;
    localparam int DIM_W   = 11;
    localparam int COORD_W = 10;
    localparam int CH_W    = 8;
    localparam int LANE_W  = 16;
    localparam int LANES   = 4;
    localparam int ENTRY_W = LANE_W * LANES;

    localparam logic [RATE_W-1:0] RATE_RESET   = 3'd1;
    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd480;
    localparam logic [DIM_W-1:0]  HEIGHT_LIMIT = 11'd1024;

    // ceil(2^22 / (s*s)) for s = 1..8, exact floor division of a 16-bit lane
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = LANE_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_TABLE [8] = '{
        23'd4194304, 23'd1048576, 23'd466034, 23'd262144,
        23'd167773,  23'd116509,  23'd85599,  23'd65536
    };

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } ssbr_cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    alpha;
        logic               first;
        logic               emit;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               done;
    } ssbr_job_t;

endpackage

>>> rtl/core/ssbr_if.sv
// sample and pixel stream interfaces
`timescale 1ns / 1ps

interface ssbr_sample_if;
    import ssbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] sample_red;
    logic [CH_W-1:0] sample_green;
    logic [CH_W-1:0] sample_blue;
    logic [CH_W-1:0] sample_alpha;
    logic            frame_start;

    modport source (
        output valid, sample_red, sample_green, sample_blue, sample_alpha, frame_start,
        input  ready
    );
    modport sink (
        input  valid, sample_red, sample_green, sample_blue, sample_alpha, frame_start,
        output ready
    );
endinterface

interface ssbr_pixel_if;
    import ssbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    pixel_red;
    logic [CH_W-1:0]    pixel_green;
    logic [CH_W-1:0]    pixel_blue;
    logic [CH_W-1:0]    pixel_alpha;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               frame_done;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
               pixel_col, pixel_row, frame_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
               pixel_col, pixel_row, frame_done,
        output ready
    );
endinterface

>>> rtl/core/supersample_box_resolve_top.sv
// supersample box resolve: top level
// the last sample of a block passes queue, accumulate and multiply stages to the output
// throughput: one sample per cycle while the queue is not full, set by one line buffer
// read and one write each cycle; the four-entry queue absorbs pixel output stalls
// reset clears counters and loads the configuration defaults (rate 1, 640 by 480)
// the line buffer is not cleared: the first sample of each block overwrites its entry
`timescale 1ns / 1ps

module supersample_box_resolve_top #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SAMPLE_RATE = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ssbr_sample_if.sink                   sample,
    ssbr_pixel_if.source                  pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssbr_pkg::PADDR_W-1:0]  paddr,
    input  logic [ssbr_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssbr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ssbr_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int QW = CW + $bits(ssbr_job_t);

    ssbr_cfg_t     cfg;
    logic          push, full, head_valid, pop;
    ssbr_job_t     job, head_job;
    logic [CW-1:0] idx, head_idx;
    logic [QW-1:0] head_data;

    ssbr_cfg #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_SAMPLE_RATE (MAX_SAMPLE_RATE)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssbr_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_SAMPLE_RATE (MAX_SAMPLE_RATE)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg),
        .full   (full),
        .push   (push),
        .job    (job),
        .idx    (idx)
    );

    ssbr_queue #(
        .DW (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({idx, job}),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    assign head_idx = head_data[QW-1 -: CW];
    assign head_job = head_data[$bits(ssbr_job_t)-1:0];

    ssbr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .head_idx   (head_idx),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule

>>> rtl/core/ssbr_cfg.sv
// configuration registers with range clamping
`timescale 1ns / 1ps

module ssbr_cfg #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SAMPLE_RATE = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssbr_pkg::PADDR_W-1:0]  paddr,
    input  logic [ssbr_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssbr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ssbr_pkg::ssbr_cfg_t           cfg
);
    import ssbr_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int RW1  = RATE_W + 1;
    localparam logic [CMPW-1:0] WIDTH_CAP = CMPW'(MAX_WIDTH);
    localparam logic [RW1-1:0]  RATE_CAP  = RW1'(MAX_SAMPLE_RATE);

    logic [RATE_W-1:0] rate_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic              wr_en;
    logic [1:0]        reg_sel;
    logic [CMPW-1:0]   width_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SAMPLE_RATE:   rate_reg   <= pwdata[RATE_W-1:0];
                REG_TARGET_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_TARGET_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SAMPLE_RATE:   prdata = PDATA_W'(rate_reg);
            REG_TARGET_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_TARGET_HEIGHT: prdata = PDATA_W'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // zero acts as one, large values saturate
    assign width_ext = CMPW'(width_reg);

    always_comb
    begin
        if (rate_reg == '0)
            cfg.rate = RATE_W'(1);
        else if ({1'b0, rate_reg} > RATE_CAP)
            cfg.rate = RATE_W'(RATE_CAP);
        else
            cfg.rate = rate_reg;

        if (width_reg == '0)
            cfg.width = DIM_W'(1);
        else if (width_ext > WIDTH_CAP)
            cfg.width = DIM_W'(WIDTH_CAP);
        else
            cfg.width = width_reg;

        if (height_reg == '0)
            cfg.height = DIM_W'(1);
        else if (height_reg > HEIGHT_LIMIT)
            cfg.height = HEIGHT_LIMIT;
        else
            cfg.height = height_reg;
    end

endmodule

>>> rtl/core/ssbr_queue.sv
// short item queue between front and back
`timescale 1ns / 1ps

module ssbr_queue #(
    parameter int DW = 56
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    output logic          head_valid,
    output logic [DW-1:0] head_data,
    input  logic          pop
);
    import ssbr_pkg::*;

    logic [DW-1:0]     slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ;
        else
        begin
            assert (!(push && full)) else $error("queue overflow");
            assert (!(pop && !head_valid)) else $error("queue underflow");
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/core/ssbr_front.sv
// sample position counters and item classification
`timescale 1ns / 1ps

module ssbr_front #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_SAMPLE_RATE = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ssbr_sample_if.sink          sample,
    input  ssbr_pkg::ssbr_cfg_t  cfg,
    input  logic                 full,
    output logic                 push,
    output ssbr_pkg::ssbr_job_t  job,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] idx
);
    import ssbr_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW  = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int SUB_W = (MAX_SAMPLE_RATE > 1) ? $clog2(MAX_SAMPLE_RATE) : 1;

    logic [SUB_W-1:0]   sub_col_reg, sub_col_next, sub_col_cur;
    logic [SUB_W-1:0]   sub_row_reg, sub_row_next, sub_row_cur;
    logic [CW-1:0]      out_col_reg, out_col_next, out_col_cur;
    logic [COORD_W-1:0] out_row_reg, out_row_next, out_row_cur;
    logic               last_sc, last_sr, last_oc, last_or;
    logic [RATE_W-1:0]  rate_m1;
    logic [CMPW-1:0]    width_m1;
    logic [DIM_W-1:0]   height_m1;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    always_comb
    begin
        // frame start restarts at block (0,0) before this sample is taken
        sub_col_cur = sample.frame_start ? '0 : sub_col_reg;
        sub_row_cur = sample.frame_start ? '0 : sub_row_reg;
        out_col_cur = sample.frame_start ? '0 : out_col_reg;
        out_row_cur = sample.frame_start ? '0 : out_row_reg;

        rate_m1   = cfg.rate - 1'b1;
        width_m1  = CMPW'(cfg.width) - 1'b1;
        height_m1 = cfg.height - 1'b1;

        last_sc = RATE_W'(sub_col_cur) >= rate_m1;
        last_sr = RATE_W'(sub_row_cur) >= rate_m1;
        last_oc = CMPW'(out_col_cur) >= width_m1;
        last_or = DIM_W'(out_row_cur) >= height_m1;

        sub_col_next = sub_col_cur;
        sub_row_next = sub_row_cur;
        out_col_next = out_col_cur;
        out_row_next = out_row_cur;
        if (!last_sc)
            sub_col_next = sub_col_cur + 1'b1;
        else
        begin
            sub_col_next = '0;
            if (!last_oc)
                out_col_next = out_col_cur + 1'b1;
            else
            begin
                out_col_next = '0;
                if (!last_sr)
                    sub_row_next = sub_row_cur + 1'b1;
                else
                begin
                    sub_row_next = '0;
                    out_row_next = last_or ? '0 : out_row_cur + 1'b1;
                end
            end
        end

        job.red   = sample.sample_red;
        job.green = sample.sample_green;
        job.blue  = sample.sample_blue;
        job.alpha = sample.sample_alpha;
        job.first = (sub_col_cur == '0) && (sub_row_cur == '0);
        job.emit  = last_sc && last_sr;
        job.col   = COORD_W'(out_col_cur);
        job.row   = out_row_cur;
        job.done  = last_oc && last_or;
        idx       = out_col_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (push)
        begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    a_emit_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        push && job.emit && job.done |=> out_col_reg == '0 && sub_row_reg == '0)
        else $error("frame end did not wrap counters");

    a_first_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        push && sample.frame_start |-> job.first && job.col == '0 && job.row == '0)
        else $error("frame start not at block origin");

    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        push && !job.emit && !sample.frame_start && sub_col_reg == '0
            && sub_row_reg == '0 |=> out_col_reg == $past(out_col_reg)
            || sub_col_reg != '0)
        else $error("column moved inside a block");

endmodule

>>> rtl/core/ssbr_back.sv
// line buffer accumulation, division and pixel output
`timescale 1ns / 1ps

module ssbr_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssbr_pkg::ssbr_cfg_t  cfg,
    input  logic                 head_valid,
    input  ssbr_pkg::ssbr_job_t  head_job,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] head_idx,
    output logic                 pop,
    ssbr_pixel_if.source         pixel
);
    import ssbr_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [ENTRY_W-1:0] line_mem [MAX_WIDTH];

    // accumulate stage
    logic               b_valid_reg;
    ssbr_job_t          b_job_reg;
    logic [CW-1:0]      b_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    // multiply stage
    logic               c_valid_reg;
    logic [PROD_W-1:0]  c_prod_reg [LANES];
    logic [COORD_W-1:0] c_col_reg;
    logic [COORD_W-1:0] c_row_reg;
    logic               c_done_reg;

    // output register
    logic               d_valid_reg;
    logic [CH_W-1:0]    d_ch_reg [LANES];
    logic [COORD_W-1:0] d_col_reg;
    logic [COORD_W-1:0] d_row_reg;
    logic               d_done_reg;

    logic               d_ready_in, c_ready_in, b_retire, wr_en;
    logic [ENTRY_W-1:0] old_entry, new_entry;
    logic [CH_W-1:0]    samp [LANES];
    logic [RECIP_W-1:0] recip;
    logic [QUOT_W-1:0]  quot [LANES];

    assign d_ready_in = !d_valid_reg || pixel.ready;
    assign c_ready_in = !c_valid_reg || d_ready_in;
    assign b_retire   = b_valid_reg && (!b_job_reg.emit || c_ready_in);
    assign pop        = head_valid && (!b_valid_reg || b_retire);
    assign wr_en      = b_retire;

    assign recip = RECIP_TABLE[cfg.rate - 1'b1];

    always_comb
    begin
        samp[0] = b_job_reg.red;
        samp[1] = b_job_reg.green;
        samp[2] = b_job_reg.blue;
        samp[3] = b_job_reg.alpha;
        // the previous item may have written this entry as it was read
        old_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        for (int k = 0; k < LANES; k++)
        begin
            if (b_job_reg.first)
                new_entry[k*LANE_W +: LANE_W] = LANE_W'(samp[k]);
            else
                new_entry[k*LANE_W +: LANE_W] =
                    old_entry[k*LANE_W +: LANE_W] + LANE_W'(samp[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[b_idx_reg] <= new_entry;
        if (pop)
            rd_data_reg <= line_mem[head_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop || b_retire)
                b_valid_reg <= pop;
            if (c_ready_in)
                c_valid_reg <= b_retire && b_job_reg.emit;
            if (d_ready_in)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_job_reg    <= head_job;
            b_idx_reg    <= head_idx;
            fwd_hit_reg  <= wr_en && (b_idx_reg == head_idx);
            fwd_data_reg <= new_entry;
        end
        if (c_ready_in && b_retire && b_job_reg.emit)
        begin
            for (int k = 0; k < LANES; k++)
                c_prod_reg[k] <= PROD_W'(new_entry[k*LANE_W +: LANE_W]) * PROD_W'(recip);
            c_col_reg  <= b_job_reg.col;
            c_row_reg  <= b_job_reg.row;
            c_done_reg <= b_job_reg.done;
        end
        if (d_ready_in && c_valid_reg)
        begin
            for (int k = 0; k < LANES; k++)
                d_ch_reg[k] <= (quot[k] > QUOT_W'(255)) ? {CH_W{1'b1}} : quot[k][CH_W-1:0];
            d_col_reg  <= c_col_reg;
            d_row_reg  <= c_row_reg;
            d_done_reg <= c_done_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
            quot[k] = c_prod_reg[k][PROD_W-1:RECIP_SHIFT];
    end

    assign pixel.valid       = d_valid_reg;
    assign pixel.pixel_red   = d_ch_reg[0];
    assign pixel.pixel_green = d_ch_reg[1];
    assign pixel.pixel_blue  = d_ch_reg[2];
    assign pixel.pixel_alpha = d_ch_reg[3];
    assign pixel.pixel_col   = d_col_reg;
    assign pixel.pixel_row   = d_row_reg;
    assign pixel.frame_done  = d_done_reg;

    a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !fwd_hit_reg || $past(wr_en))
        else $error("forwarded entry without a write");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_retire |=> b_valid_reg && $stable(b_job_reg))
        else $error("accumulate stage lost its item");

    a_emit_reaches_mult: assert property (@(posedge clk) disable iff (!rst_n)
        b_retire && b_job_reg.emit |=> c_valid_reg)
        else $error("finished block not passed to divider");

endmodule
